/* src/at_command_response_sequencer_defines.svh */
`ifndef AT_COMMAND_RESPONSE_SEQUENCER_DEFINES_SVH
`define AT_COMMAND_RESPONSE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ATCRS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("atcrs: check failed");

// Next-cycle implication, disabled while in reset.
`define ATCRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("atcrs: check failed");

`endif

/* src/atcrs_pkg.sv */
package atcrs_pkg;

    typedef enum logic [1:0] {
        FN_START   = 2'd0,
        FN_BYTE    = 2'd1,
        FN_TICK    = 2'd2,
        FN_RELEASE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_GUARD = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    localparam int TICK_WIDTH_DEF = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // register indexes on the APB port
    localparam logic [2:0] REG_LINE_LIMIT      = 3'd0;
    localparam logic [2:0] REG_REPLY_TIMEOUT   = 3'd1;
    localparam logic [2:0] REG_BALANCE_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_RETRY_LIMIT     = 3'd3;
    localparam logic [2:0] REG_GUARD_DELAY     = 3'd4;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_PLUS = 8'h2B;

    // tails, newest byte lowest
    localparam logic [31:0] TAIL_OK    = 32'h4F4B_0D0A;
    localparam logic [55:0] TAIL_ERROR = 56'h45_5252_4F52_0D0A;

    localparam int CUSD_LEN = 6;

    function automatic logic [7:0] cusd_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h2B; // +
            3'd1:    c = 8'h43; // C
            3'd2:    c = 8'h55; // U
            3'd3:    c = 8'h53; // S
            3'd4:    c = 8'h44; // D
            3'd5:    c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    typedef struct packed {
        func_t               func;
        logic [7:0]          rx_byte;
        logic                has_data;
        logic                balance_mode;
        logic                is_crlf;
        logic                is_lf;
        logic                is_gt;
        logic                is_plus;
        logic [CUSD_LEN-1:0] cusd_hit;
    } item_t;

    // packed MSB first: accepted ends up in bit 0
    typedef struct packed {
        logic       timed_out;
        logic       ok;
        logic [1:0] phase;
        logic       send_data;
        logic       send_command;
        logic       accepted;
    } result_t;

    typedef struct packed {
        logic [7:0]  line_limit;
        logic [31:0] reply_timeout;
        logic [31:0] balance_timeout;
        logic [7:0]  retry_limit;
        logic [31:0] guard_delay;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* src/atcrs_front.sv */
module atcrs_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  atcrs_pkg::q_status_t q_status,
    output logic                push,
    output atcrs_pkg::item_t    push_item
);

    logic [7:0] b;

    assign b        = s_tdata[7:0];
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    always_comb begin
        push_item              = '0;
        push_item.func         = atcrs_pkg::func_t'(s_tuser[1:0]);
        push_item.rx_byte      = b;
        push_item.has_data     = s_tdata[8];
        push_item.balance_mode = s_tdata[9];
        push_item.is_crlf      = (b == atcrs_pkg::CH_CR) || (b == atcrs_pkg::CH_LF);
        push_item.is_lf        = (b == atcrs_pkg::CH_LF);
        push_item.is_gt        = (b == atcrs_pkg::CH_GT);
        push_item.is_plus      = (b == atcrs_pkg::CH_PLUS);
        for (int i = 0; i < atcrs_pkg::CUSD_LEN; i++) begin
            push_item.cusd_hit[i] = (b == atcrs_pkg::cusd_char(3'(i)));
        end
    end

endmodule

/* src/atcrs_queue.sv */
module atcrs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  atcrs_pkg::item_t     push_item,
    input  logic                 pop,
    output atcrs_pkg::item_t     head_item,
    output atcrs_pkg::q_status_t q_status
);

    localparam int PW = atcrs_pkg::Q_PTR_W;
    localparam int CW = atcrs_pkg::Q_CNT_W;

    atcrs_pkg::item_t entry_reg [atcrs_pkg::Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(atcrs_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_status.full  = (count_reg == CW'(atcrs_pkg::Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_item      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/atcrs_back.sv */
module atcrs_back #(
    parameter int TICK_WIDTH = atcrs_pkg::TICK_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  atcrs_pkg::cfg_t      cfg,
    input  atcrs_pkg::item_t     head_item,
    input  atcrs_pkg::q_status_t q_status,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output atcrs_pkg::phase_t    phase
);

    localparam int CMP_W = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

    typedef struct packed {
        logic start;
        logic release_ok;
        logic rx;
        logic keep;
        logic succ;
        logic prompt;
        logic error;
        logic tick;
        logic wait_expire;
        logic retry;
        logic tmo_fail;
        logic guard_end;
    } ev_t;

    atcrs_pkg::phase_t phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [7:0]  sends_reg, sends_next;
    logic [7:0]  linepos_reg, linepos_next;
    logic [55:0] tail_reg, tail_next;
    logic [2:0]  prog_reg, prog_next;
    logic found_reg, found_next;
    logic ok_reg, ok_next;
    logic tmo_reg, tmo_next;
    logic bal_reg, bal_next;
    logic pay_reg, pay_next;

    logic              m_valid_reg;
    atcrs_pkg::result_t res_reg;
    atcrs_pkg::result_t res_next;

    logic take;
    ev_t  ev;
    logic [7:0]  lp_base;
    logic [55:0] tail_new;
    logic        ok_match, err_match, cusd_hit_cur;
    logic [TICK_WIDTH-1:0] el_inc;
    logic [CMP_W-1:0]      el_cmp;
    logic [7:0]  sends_inc;
    logic        under_retry;

    assign take     = !q_status.empty && (!m_valid_reg || m_tready);
    assign pop      = take;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg};
    assign phase    = phase_reg;

    // event decode
    always_comb begin
        lp_base   = head_item.is_crlf ? 8'd0 : linepos_reg;
        tail_new  = {tail_reg[47:0], head_item.rx_byte};
        ok_match  = (tail_new[31:0] == atcrs_pkg::TAIL_OK);
        err_match = (tail_new == atcrs_pkg::TAIL_ERROR);
        case (prog_reg)
            3'd0:    cusd_hit_cur = head_item.cusd_hit[0];
            3'd1:    cusd_hit_cur = head_item.cusd_hit[1];
            3'd2:    cusd_hit_cur = head_item.cusd_hit[2];
            3'd3:    cusd_hit_cur = head_item.cusd_hit[3];
            3'd4:    cusd_hit_cur = head_item.cusd_hit[4];
            3'd5:    cusd_hit_cur = head_item.cusd_hit[5];
            default: cusd_hit_cur = 1'b0;
        endcase
        el_inc      = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
        el_cmp      = CMP_W'(el_inc);
        sends_inc   = (sends_reg == 8'hFF) ? sends_reg : sends_reg + 1'b1;
        under_retry = (sends_inc < cfg.retry_limit);

        ev            = '0;
        ev.start      = take && (head_item.func == atcrs_pkg::FN_START)
                        && (phase_reg == atcrs_pkg::PH_IDLE);
        ev.release_ok = take && (head_item.func == atcrs_pkg::FN_RELEASE)
                        && (phase_reg == atcrs_pkg::PH_DONE);
        ev.rx         = take && (head_item.func == atcrs_pkg::FN_BYTE)
                        && (phase_reg == atcrs_pkg::PH_WAIT);
        ev.keep       = ev.rx && ((lp_base < cfg.line_limit) || bal_reg);
        ev.succ       = ev.keep && (bal_reg ? (found_reg && head_item.is_lf) : ok_match);
        ev.prompt     = ev.keep && !bal_reg && !ok_match && pay_reg && head_item.is_gt;
        ev.error      = ev.keep && !bal_reg && !ok_match
                        && !(pay_reg && head_item.is_gt) && err_match;
        ev.tick       = take && (head_item.func == atcrs_pkg::FN_TICK)
                        && ((phase_reg == atcrs_pkg::PH_WAIT)
                            || (phase_reg == atcrs_pkg::PH_GUARD));
        ev.wait_expire = ev.tick && (phase_reg == atcrs_pkg::PH_WAIT)
                         && (el_cmp > (bal_reg ? CMP_W'(cfg.balance_timeout)
                                               : CMP_W'(cfg.reply_timeout)));
        ev.retry      = ev.wait_expire && !bal_reg && under_retry;
        ev.tmo_fail   = ev.wait_expire && (bal_reg || !under_retry);
        ev.guard_end  = ev.tick && (phase_reg == atcrs_pkg::PH_GUARD)
                        && (el_cmp > CMP_W'(cfg.guard_delay));
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            atcrs_pkg::PH_IDLE: begin
                if (ev.start) phase_next = atcrs_pkg::PH_WAIT;
            end
            atcrs_pkg::PH_WAIT: begin
                if (ev.succ || ev.error || ev.tmo_fail) phase_next = atcrs_pkg::PH_GUARD;
            end
            atcrs_pkg::PH_GUARD: begin
                if (ev.guard_end) phase_next = atcrs_pkg::PH_DONE;
            end
            atcrs_pkg::PH_DONE: begin
                if (ev.release_ok) phase_next = atcrs_pkg::PH_IDLE;
            end
            default: phase_next = atcrs_pkg::PH_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        elapsed_next = elapsed_reg;
        sends_next   = sends_reg;
        linepos_next = linepos_reg;
        tail_next    = tail_reg;
        prog_next    = prog_reg;
        found_next   = found_reg;
        ok_next      = ok_reg;
        tmo_next     = tmo_reg;
        bal_next     = bal_reg;
        pay_next     = pay_reg;

        if (ev.start) begin
            pay_next   = head_item.has_data;
            bal_next   = head_item.balance_mode;
            sends_next = 8'd0;
        end

        // CR and LF restart the line count even when the byte is dropped
        if (ev.rx) begin
            linepos_next = lp_base;
        end

        if (ev.keep) begin
            tail_next    = tail_new;
            linepos_next = (lp_base == 8'hFF) ? lp_base : lp_base + 1'b1;
            if (bal_reg && !found_reg) begin
                if (cusd_hit_cur) begin
                    if (prog_reg == 3'(atcrs_pkg::CUSD_LEN - 1)) begin
                        found_next = 1'b1;
                        prog_next  = 3'd0;
                    end else begin
                        prog_next = prog_reg + 1'b1;
                    end
                end else begin
                    prog_next = head_item.is_plus ? 3'd1 : 3'd0;
                end
            end
        end

        if (ev.tick) begin
            elapsed_next = el_inc;
        end
        if (ev.wait_expire && !bal_reg) begin
            sends_next = sends_inc;
        end

        if (ev.succ) begin
            ok_next = 1'b1;
        end
        if (ev.error) begin
            ok_next  = 1'b0;
            tmo_next = 1'b0;
        end
        if (ev.tmo_fail) begin
            ok_next  = 1'b0;
            tmo_next = 1'b1;
        end
        if (ev.succ || ev.error || ev.tmo_fail) begin
            elapsed_next = '0;
        end

        // restart of the reply wait
        if (ev.start || ev.prompt || ev.retry) begin
            tail_next    = '0;
            linepos_next = 8'd0;
            prog_next    = 3'd0;
            found_next   = 1'b0;
            elapsed_next = '0;
        end

        res_next.accepted     = ev.start || ev.release_ok;
        res_next.send_command = ev.start || ev.retry;
        res_next.send_data    = ev.prompt;
        res_next.phase        = phase_next;
        res_next.ok           = ok_next;
        res_next.timed_out    = tmo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= atcrs_pkg::PH_IDLE;
            elapsed_reg <= '0;
            sends_reg   <= '0;
            linepos_reg <= '0;
            tail_reg    <= '0;
            prog_reg    <= '0;
            found_reg   <= 1'b0;
            ok_reg      <= 1'b0;
            tmo_reg     <= 1'b0;
            bal_reg     <= 1'b0;
            pay_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            sends_reg   <= sends_next;
            linepos_reg <= linepos_next;
            tail_reg    <= tail_next;
            prog_reg    <= prog_next;
            found_reg   <= found_next;
            ok_reg      <= ok_next;
            tmo_reg     <= tmo_next;
            bal_reg     <= bal_next;
            pay_reg     <= pay_next;
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

endmodule

/* src/at_command_response_sequencer.sv */
// Modem command handshake sequencer. Each input transfer (start, received byte,
// tick or release, selected by s_tuser) yields exactly one result transfer that
// carries the send requests and the phase and status after that item. The block
// takes one item per clock while its queue has room: the front stage classifies
// the byte and writes a two-entry queue, the back stage updates the handshake
// state and loads the output register from the queue head, and up to two more
// items are taken while the output is stalled.
// Registers on the APB port sit at byte address 4*index and are meant to be
// written while no item is in flight.
`include "at_command_response_sequencer_defines.svh"

module at_command_response_sequencer #(
    parameter int TICK_WIDTH = atcrs_pkg::TICK_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], has_data[8], balance_mode[9], zero
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // accepted[0], send_command[1], send_data[2],
                                   // phase[4:3], ok[5], timed_out[6], zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    atcrs_pkg::cfg_t      cfg_reg;
    atcrs_pkg::q_status_t q_status;
    atcrs_pkg::item_t     push_item;
    atcrs_pkg::item_t     head_item;
    atcrs_pkg::phase_t    phase;
    logic                 push;
    logic                 pop;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_limit      <= 8'd64;
            cfg_reg.reply_timeout   <= 32'd5000;
            cfg_reg.balance_timeout <= 32'd25000000;
            cfg_reg.retry_limit     <= 8'd3;
            cfg_reg.guard_delay     <= 32'd1000;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                atcrs_pkg::REG_LINE_LIMIT:      cfg_reg.line_limit      <= pwdata[7:0];
                atcrs_pkg::REG_REPLY_TIMEOUT:   cfg_reg.reply_timeout   <= pwdata;
                atcrs_pkg::REG_BALANCE_TIMEOUT: cfg_reg.balance_timeout <= pwdata;
                atcrs_pkg::REG_RETRY_LIMIT:     cfg_reg.retry_limit     <= pwdata[7:0];
                atcrs_pkg::REG_GUARD_DELAY:     cfg_reg.guard_delay     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            atcrs_pkg::REG_LINE_LIMIT:      prdata = {24'd0, cfg_reg.line_limit};
            atcrs_pkg::REG_REPLY_TIMEOUT:   prdata = cfg_reg.reply_timeout;
            atcrs_pkg::REG_BALANCE_TIMEOUT: prdata = cfg_reg.balance_timeout;
            atcrs_pkg::REG_RETRY_LIMIT:     prdata = {24'd0, cfg_reg.retry_limit};
            atcrs_pkg::REG_GUARD_DELAY:     prdata = cfg_reg.guard_delay;
            default:                        prdata = 32'd0;
        endcase
    end

    atcrs_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    atcrs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    atcrs_back #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head_item (head_item),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .phase     (phase)
    );

    // a data send is only requested while the reply wait stays open
    `ATCRS_ASSERT_NOW(a_data_in_wait, aclk, aresetn, m_tvalid && m_tdata[2], m_tdata[4:3] == atcrs_pkg::PH_WAIT)
    // an accepted start lands in wait, an accepted release in idle
    `ATCRS_ASSERT_NOW(a_accept_phase, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[4:3] == atcrs_pkg::PH_IDLE || m_tdata[4:3] == atcrs_pkg::PH_WAIT)
    // a queued item with a free output register shows up next cycle
    `ATCRS_ASSERT_NEXT(a_queue_drains, aclk, aresetn, !q_status.empty && !m_tvalid, m_tvalid && m_tdata[4:3] == phase)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import atcrs_pkg::*;

    // register slot with no register behind it
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [47:0] CUSD_TEXT = "+CUSD:";
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        func_t      func;
        logic [7:0] data;
        logic       has_data;
        logic       balance;
    } stim_t;

    typedef struct packed {
        logic   accepted;
        logic   send_command;
        logic   send_data;
        phase_t phase;
        logic   ok;
        logic   timed_out;
    } reply_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // rx_byte[7:0], has_data[8], balance_mode[9], zero
    logic [1:0]  s_tuser = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // accepted[0], send_command[1], send_data[2],
                                 // phase[4:3], ok[5], timed_out[6], zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    at_command_response_sequencer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // sequencer state as predicted
    phase_t      seq_phase = PH_IDLE;
    logic [31:0] tick_count = '0;
    logic [7:0]  send_count = '0;
    logic [7:0]  line_pos = '0;
    logic [55:0] rx_tail = '0;
    logic [2:0]  cusd_pos = '0;
    logic        cusd_seen = 1'b0;
    logic        ok_st = 1'b0;
    logic        timeout_st = 1'b0;
    logic        balance_on = 1'b0;
    logic        payload_on = 1'b0;

    logic [7:0]  lim_line = 8'd64;
    logic [31:0] lim_reply = 32'd5000;
    logic [31:0] lim_balance = 32'd25_000_000;
    logic [7:0]  lim_retry = 8'd3;
    logic [31:0] lim_guard = 32'd1000;

    stim_t  items_to_send[$];
    reply_t replies_due[$];
    int     errors = 0;
    int     stim_total = 0;
    int     gap_pct = 18;
    int     stall_pct = 18;
    int     hold_requests = 0;
    int     holds_done = 0;
    int     hold_left = 0;
    logic   in_took = 1'b0;

    function automatic void reopen_wait();
        rx_tail = '0;
        line_pos = '0;
        cusd_pos = '0;
        cusd_seen = 1'b0;
        tick_count = '0;
        seq_phase = PH_WAIT;
    endfunction

    function automatic void enter_guard();
        tick_count = '0;
        seq_phase = PH_GUARD;
    endfunction

    function automatic reply_t advance_sequencer(input stim_t it);
        reply_t r;
        r.accepted = 1'b0;
        r.send_command = 1'b0;
        r.send_data = 1'b0;
        case (it.func)
            FN_START: begin
                if (seq_phase == PH_IDLE) begin
                    r.accepted = 1'b1;
                    payload_on = it.has_data;
                    balance_on = it.balance;
                    send_count = '0;
                    r.send_command = 1'b1;
                    reopen_wait();
                end
            end
            FN_BYTE: begin
                if (seq_phase == PH_WAIT) begin
                    if (it.data == CH_CR || it.data == CH_LF)
                        line_pos = '0;
                    if (line_pos < lim_line || balance_on) begin
                        rx_tail = {rx_tail[47:0], it.data};
                        if (line_pos != 8'hFF)
                            line_pos++;
                        if (balance_on) begin
                            if (cusd_seen) begin
                                if (it.data == CH_LF) begin
                                    ok_st = 1'b1;
                                    enter_guard();
                                end
                            end else if (it.data == CUSD_TEXT[8 * (5 - int'(cusd_pos)) +: 8]) begin
                                cusd_pos++;
                                if (cusd_pos >= 3'd6) begin
                                    cusd_seen = 1'b1;
                                    cusd_pos = '0;
                                end
                            end else begin
                                cusd_pos = (it.data == CH_PLUS) ? 3'd1 : 3'd0;
                            end
                        end else if (rx_tail[31:0] == TAIL_OK) begin
                            ok_st = 1'b1;
                            enter_guard();
                        end else if (payload_on && rx_tail[7:0] == CH_GT) begin
                            r.send_data = 1'b1;
                            reopen_wait();
                        end else if (rx_tail == TAIL_ERROR) begin
                            ok_st = 1'b0;
                            timeout_st = 1'b0;
                            enter_guard();
                        end
                    end
                end
            end
            FN_TICK: begin
                if ((seq_phase == PH_WAIT || seq_phase == PH_GUARD) && tick_count != '1)
                    tick_count++;
                if (seq_phase == PH_WAIT) begin
                    if (balance_on) begin
                        if (tick_count > lim_balance) begin
                            ok_st = 1'b0;
                            timeout_st = 1'b1;
                            enter_guard();
                        end
                    end else if (tick_count > lim_reply) begin
                        if (send_count != 8'hFF)
                            send_count++;
                        if (send_count < lim_retry) begin
                            r.send_command = 1'b1;
                            reopen_wait();
                        end else begin
                            ok_st = 1'b0;
                            timeout_st = 1'b1;
                            enter_guard();
                        end
                    end
                end else if (seq_phase == PH_GUARD) begin
                    if (tick_count > lim_guard)
                        seq_phase = PH_DONE;
                end
            end
            FN_RELEASE: begin
                if (seq_phase == PH_DONE) begin
                    r.accepted = 1'b1;
                    seq_phase = PH_IDLE;
                end
            end
        endcase
        r.phase = seq_phase;
        r.ok = ok_st;
        r.timed_out = timeout_st;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // sender
    always @(negedge aclk) begin
        stim_t nx;
        if (!aresetn || (s_tvalid && !in_took)) begin
            // offer stays up until transfer
        end else if (items_to_send.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
            nx = items_to_send.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= nx.func;
            s_tdata <= {6'b0, nx.balance, nx.has_data, nx.data};
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver, with long hold-offs on request
    always @(negedge aclk) begin
        if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor: predict on input transfers, check result transfers
    always @(posedge aclk) begin
        stim_t  it;
        reply_t want;
        reply_t got;
        in_took = aresetn && s_tvalid && s_tready;
        if (in_took) begin
            it.func = func_t'(s_tuser);
            it.data = s_tdata[7:0];
            it.has_data = s_tdata[8];
            it.balance = s_tdata[9];
            replies_due.push_back(advance_sequencer(it));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.accepted = m_tdata[0];
            got.send_command = m_tdata[1];
            got.send_data = m_tdata[2];
            got.phase = phase_t'(m_tdata[4:3]);
            got.ok = m_tdata[5];
            got.timed_out = m_tdata[6];
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
            end else begin
                want = replies_due.pop_front();
                check_field("accepted", 2'(want.accepted), 2'(got.accepted));
                check_field("send_command", 2'(want.send_command), 2'(got.send_command));
                check_field("send_data", 2'(want.send_data), 2'(got.send_data));
                check_field("phase", want.phase, got.phase);
                check_field("ok", 2'(want.ok), 2'(got.ok));
                check_field("timed_out", 2'(want.timed_out), 2'(got.timed_out));
                if (m_tdata[7] !== 1'b0)
                    check_field("pad", 2'd0, {1'b0, m_tdata[7]});
            end
        end
    end

    task automatic push_item(input func_t f, input logic [7:0] b, input logic hd, input logic bm);
        stim_t it;
        it.func = f;
        it.data = b;
        it.has_data = hd;
        it.balance = bm;
        items_to_send.push_back(it);
        stim_total++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(FN_BYTE, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic push_start(input logic hd, input logic bm);
        push_item(FN_START, 8'($urandom_range(0, 255)), hd, bm);
    endtask

    task automatic push_release();
        push_item(FN_RELEASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic push_ticks(input int n);
        repeat (n)
            push_item(FN_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic push_line(input int len, input bit terminate);
        repeat (len)
            push_byte(8'($urandom_range(8'h21, 8'h7E)));
        if (terminate)
            push_crlf();
    endtask

    task automatic push_chatter(input int len);
        logic [7:0] b;
        repeat (len) begin
            case ($urandom_range(0, 7))
                0:       b = CH_CR;
                1:       b = CH_LF;
                2:       b = 8'($urandom_range(0, 255));
                default: b = 8'($urandom_range(8'h20, 8'h7E));
            endcase
            push_byte(b);
        end
    endtask

    function automatic int capped(input longint v, input int top);
        return (v > top) ? top : int'(v);
    endfunction

    task automatic run_exchange();
        bit          bm;
        bit          hd;
        int unsigned kind;
        if ($urandom_range(0, 9) == 0) begin
            // noise: anything in any phase
            repeat ($urandom_range(3, 8))
                push_item(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            return;
        end
        bm = ($urandom_range(0, 3) == 0);
        hd = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 4);
        push_start(hd, bm);
        if ($urandom_range(0, 7) == 0)
            push_start(~hd, bm);
        if (!bm) begin
            if (hd && $urandom_range(0, 1)) begin
                push_chatter($urandom_range(0, 4));
                push_byte(CH_GT);
            end
            repeat ($urandom_range(0, 2))
                push_line(($urandom_range(0, 4) == 0) ? int'(lim_line) + $urandom_range(1, 10)
                                                      : $urandom_range(0, 12), 1'b1);
            if ($urandom_range(0, 3) == 0)
                push_ticks($urandom_range(0, 3));
            case (kind)
                0, 1: begin
                    push_text("OK");
                    push_crlf();
                end
                2: begin
                    push_text("ERROR");
                    push_crlf();
                end
                default: begin
                    // a full line swallows the OK, so only the retries end it
                    if (kind == 3) begin
                        push_line(lim_line, 1'b0);
                        push_text("OK");
                        push_crlf();
                    end
                    push_ticks(capped((longint'(lim_reply) + 1) * lim_retry, 400));
                end
            endcase
        end else begin
            push_chatter($urandom_range(0, 6));
            if (kind == 4) begin
                push_ticks(capped(longint'(lim_balance) + 1, 400));
            end else begin
                if ($urandom_range(0, 2) == 0)
                    push_text("+CU");
                push_text("+CUSD:");
                push_chatter((kind == 3 && $urandom_range(0, 3) == 0) ? 270 : $urandom_range(0, 16));
                push_byte(CH_LF);
            end
        end
        if ($urandom_range(0, 5) == 0)
            push_release();
        push_ticks(capped(longint'(lim_guard) + 1 + $urandom_range(0, 1), 300));
        if ($urandom_range(0, 5) == 0)
            push_byte(8'($urandom_range(0, 255)));
        push_release();
    endtask

    task automatic fill_to(input int goal);
        while (stim_total < goal)
            run_exchange();
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LINE_LIMIT:      lim_line = val[7:0];
            REG_REPLY_TIMEOUT:   lim_reply = val;
            REG_BALANCE_TIMEOUT: lim_balance = val;
            REG_RETRY_LIMIT:     lim_retry = val[7:0];
            REG_GUARD_DELAY:     lim_guard = val;
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input logic [7:0] line, input logic [31:0] reply,
                             input logic [31:0] bal, input logic [7:0] retry,
                             input logic [31:0] guard);
        // upper bits of the byte-wide registers must be dropped
        reg_write(REG_LINE_LIMIT, ($urandom() & 32'hFFFF_FF00) | 32'(line));
        reg_write(REG_REPLY_TIMEOUT, reply);
        reg_write(REG_BALANCE_TIMEOUT, bal);
        reg_write(REG_RETRY_LIMIT, ($urandom() & 32'hFFFF_FF00) | 32'(retry));
        reg_write(REG_GUARD_DELAY, guard);
        reg_write(REG_UNUSED, $urandom());
    endtask

    task automatic settle();
        while (items_to_send.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: line limit stays at its reset value
        reg_write(REG_REPLY_TIMEOUT, 32'd1);
        reg_write(REG_BALANCE_TIMEOUT, 32'd2);
        reg_write(REG_RETRY_LIMIT, 32'd2);
        reg_write(REG_GUARD_DELAY, 32'd0);
        push_release();
        push_ticks(1);
        push_byte(8'hFF);
        push_start(1'b1, 1'b0);
        push_start(1'b0, 1'b1);
        push_release();
        push_byte(CH_GT);
        push_text("OK");
        push_crlf();
        push_ticks(2);
        push_byte(8'h00);
        push_release();
        push_start(1'b0, 1'b1);
        push_text("+CUSD:");
        push_byte(CH_LF);
        push_ticks(1);
        push_release();
        settle();

        // low extremes, back-to-back transfers
        apply_cfg(8'd8, 32'd0, 32'd0, 8'd1, 32'd0);
        gap_pct = 0;
        stall_pct = 0;
        fill_to(stim_total + 250);
        settle();
        gap_pct = 18;
        stall_pct = 18;

        // long receiver hold-off while items keep coming
        apply_cfg(8'd255, 32'd3, 32'd5, 8'd3, 32'd2);
        fill_to(stim_total + 250);
        hold_requests++;
        settle();

        // maximum retry count
        apply_cfg(8'd64, 32'd0, 32'd1, 8'd255, 32'd1);
        repeat (3) run_exchange();
        settle();

        // timeouts that never run out
        apply_cfg(8'($urandom_range(8, 255)), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,
                  32'hFFFF_FFFF);
        repeat (2) run_exchange();
        settle();

        while (stim_total < 1500) begin
            apply_cfg(8'($urandom_range(8, 40)), 32'($urandom_range(0, 6)),
                      32'($urandom_range(0, 15)), 8'($urandom_range(1, 4)),
                      32'($urandom_range(0, 4)));
            fill_to(stim_total + 150);
            settle();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
